[hdl/erom_core_descriptor_scan_unit_assert.svh]
// ----------------------------------------------------------------------------
// Descriptor scan unit - assertion macros
// Clocked property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef EROM_CORE_DESCRIPTOR_SCAN_UNIT_ASSERT_SVH
`define EROM_CORE_DESCRIPTOR_SCAN_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ECDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ECDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ecds_pkg.sv]
// ----------------------------------------------------------------------------
// Descriptor scan package
// Types, codes and constants shared by the scan step logic and the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecds_pkg;

    // pass limit of the address walk and width of its counters
    localparam int SAFETY_LIMIT = 256;
    localparam int CNT_W        = $clog2(SAFETY_LIMIT + 1);

    localparam logic [31:0] WORD_STEP = 32'd4;

    // descriptor tags (low nibble)
    localparam logic [3:0] TAG_COMP  = 4'h1;
    localparam logic [3:0] TAG_MPORT = 4'h3;
    localparam logic [3:0] TAG_END   = 4'hf;
    // address descriptor, with or without the high-address flag in bit 3
    localparam logic [2:0] TAG_ADDR  = 3'd5;

    // address descriptor size code that carries a size word
    localparam logic [1:0] SZ_SIZE     = 2'd3;
    // address descriptor space types
    localparam logic [1:0] ST_SLAVE    = 2'd0;
    localparam logic [1:0] WRAP_SLAVE  = 2'd2;
    localparam logic [1:0] WRAP_MASTER = 2'd3;

    // configuration register indexes
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_BASE   = 1'b1;

    typedef enum logic [9:0] {
        PH_IDLE         = 10'b00_0000_0001,
        PH_FIND         = 10'b00_0000_0010,
        PH_COMP2        = 10'b00_0000_0100,
        PH_FIRST        = 10'b00_0000_1000,
        PH_SCAN         = 10'b00_0001_0000,
        PH_SKIP_HI      = 10'b00_0010_0000,
        PH_SKIP_HI_SIZE = 10'b00_0100_0000,
        PH_SIZE         = 10'b00_1000_0000,
        PH_SKIP_SIZE_HI = 10'b01_0000_0000,
        PH_DONE         = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [31:0]        read_addr;
        logic [11:0]        cur_part;
        logic [7:0]         cur_rev;
        logic [1:0]         wrap_kind;
        logic [19:0]        found_reg;
        logic [19:0]        found_wrap;
        logic [CNT_W-1:0]   inner;
        logic [CNT_W-1:0]   outer;
        logic               fin_skip;
    } t_scan_state;

    typedef struct packed {
        logic [31:0] next_read_addr;
        logic        scan_done;
        logic        core_found;
        logic [11:0] core_part;
        logic [7:0]  core_revision;
        logic [31:0] reg_base;
        logic [31:0] wrapper_base;
    } t_result;

    localparam t_scan_state STATE_RESET = '{
        phase:      PH_IDLE,
        read_addr:  32'd0,
        cur_part:   12'd0,
        cur_rev:    8'd0,
        wrap_kind:  2'd0,
        found_reg:  20'd0,
        found_wrap: 20'd0,
        inner:      '0,
        outer:      '0,
        fin_skip:   1'b0
    };

endpackage

[hdl/erom_core_descriptor_scan_unit.sv]
// ----------------------------------------------------------------------------
// Enumeration ROM descriptor scan unit
// Walks descriptor words after a start transaction, reports the next read
// address each step and the part, revision and window bases of the target
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------
//  input    | in        | i_in_valid / o_in_ready     | i_func, i_desc_word
//  result   | out       | o_out_valid / i_out_ready   | o_next_read_addr .. base
//  config   | in        | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
//  one transaction per cycle while the result is not stalled: the step logic
//  sits between the scan state registers and the result register, and a word
//  handed back is rescanned in the same cycle
//  one result register; a new transaction is taken whenever it is empty or
//  being drained, so a stalled result only stops the input
//  synchronous active-low reset: scan idle, state and config registers zero, result empty
//
`timescale 1ns / 1ps

module erom_core_descriptor_scan_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_desc_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_next_read_addr,
    output logic        o_scan_done,
    output logic        o_core_found,
    output logic [11:0] o_core_part,
    output logic [7:0]  o_core_revision,
    output logic [31:0] o_reg_base,
    output logic [31:0] o_wrapper_base
);
    import ecds_pkg::*;

    t_scan_state r_state;
    t_scan_state n_state;
    t_result     r_out;
    t_result     n_out;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [11:0] r_target;
    logic [31:0] r_table_base;
    logic        accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign n_out_valid = accept || (r_out_valid && !i_out_ready);

    ecds_step u_step (
        .i_state      (r_state),
        .i_func       (i_func),
        .i_word       (i_desc_word),
        .i_target     (r_target),
        .i_table_base (r_table_base),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= STATE_RESET;
            r_out_valid  <= 1'b0;
            r_target     <= 12'd0;
            r_table_base <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET: r_target     <= i_cfg_data[11:0];
                    CFG_BASE:   r_table_base <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_state <= n_state;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_next_read_addr = r_out.next_read_addr;
    assign o_scan_done      = r_out.scan_done;
    assign o_core_found     = r_out.core_found;
    assign o_core_part      = r_out.core_part;
    assign o_core_revision  = r_out.core_revision;
    assign o_reg_base       = r_out.reg_base;
    assign o_wrapper_base   = r_out.wrapper_base;

endmodule

[hdl/ecds_step.sv]
// ----------------------------------------------------------------------------
// Descriptor scan step
// Next scan state and result for one transaction, including the rescan of a
// word handed back to the find phase or on to the address walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecds_step (
    input  ecds_pkg::t_scan_state i_state,
    input  logic                  i_func,
    input  logic [31:0]           i_word,
    input  logic [11:0]           i_target,
    input  logic [31:0]           i_table_base,
    output ecds_pkg::t_scan_state o_state,
    output ecds_pkg::t_result     o_result
);
    import ecds_pkg::*;

    t_scan_state s;
    logic [3:0]  tag;
    logic [1:0]  sz;
    logic [1:0]  st;
    logic        done;
    logic        hit;
    logic        do_scan;
    logic        do_find;
    logic        end_pass;
    logic        end_walk;
    logic        rescan;
    logic        fin;
    logic        take;

    assign tag = i_word[3:0];
    assign sz  = i_word[5:4];
    assign st  = i_word[7:6];

    always_comb begin
        s        = i_state;
        done     = 1'b0;
        hit      = 1'b0;
        do_scan  = 1'b0;
        do_find  = 1'b0;
        end_pass = 1'b0;
        end_walk = 1'b0;
        rescan   = 1'b0;
        fin      = 1'b0;
        take     = 1'b0;

        if (i_func) begin
            s           = STATE_RESET;
            s.phase     = PH_FIND;
            s.read_addr = i_table_base;
        end else begin
            unique case (i_state.phase)
                PH_FIND: begin
                    do_find = 1'b1;
                end
                PH_COMP2: begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    s.cur_rev   = i_word[31:24];
                    // no master and no slave wrappers: skip the component
                    if (i_word[18:14] == 5'd0 && i_word[23:19] == 5'd0) begin
                        s.phase = PH_FIND;
                    end else begin
                        s.found_reg  = 20'd0;
                        s.found_wrap = 20'd0;
                        s.phase      = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    s.inner    = '0;
                    s.outer    = '0;
                    s.fin_skip = 1'b0;
                    if (tag == TAG_MPORT) begin
                        s.read_addr = s.read_addr + WORD_STEP;
                        s.wrap_kind = WRAP_MASTER;
                        s.phase     = PH_SCAN;
                    end else if (tag[2:0] == TAG_ADDR) begin
                        // same word goes straight into the address walk
                        s.wrap_kind = WRAP_SLAVE;
                        do_scan     = 1'b1;
                    end else begin
                        end_walk = 1'b1;
                        rescan   = 1'b1;
                    end
                end
                PH_SCAN: begin
                    do_scan = 1'b1;
                end
                PH_SKIP_HI: begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    if (s.fin_skip) begin
                        end_walk = 1'b1;
                    end else begin
                        end_pass = 1'b1;
                    end
                end
                PH_SKIP_HI_SIZE: begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    s.phase     = PH_SIZE;
                end
                PH_SIZE: begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    if (i_word[3]) begin
                        s.phase = PH_SKIP_SIZE_HI;
                    end else begin
                        end_pass = 1'b1;
                    end
                end
                PH_SKIP_SIZE_HI: begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    end_pass    = 1'b1;
                end
                default: begin
                    // idle or done: word ignored
                end
            endcase

            if (do_scan) begin
                if (tag == TAG_END || tag == TAG_COMP) begin
                    end_walk = 1'b1;
                    rescan   = 1'b1;
                end else begin
                    s.read_addr = s.read_addr + WORD_STEP;
                    if (tag[2:0] == TAG_ADDR) begin
                        take = 1'b1;
                    end else begin
                        s.inner = s.inner + CNT_W'(1);
                        // pass limit: the word counts as an address entry
                        take    = (s.inner >= CNT_W'(SAFETY_LIMIT));
                    end
                end
            end

            if (take) begin
                if (!sz[1]) begin
                    if (s.found_reg == 20'd0 && st == ST_SLAVE) begin
                        s.found_reg = i_word[31:12];
                    end
                    if (s.found_wrap == 20'd0 && st == s.wrap_kind) begin
                        s.found_wrap = i_word[31:12];
                    end
                    fin = (s.found_reg != 20'd0) && (s.found_wrap != 20'd0);
                end
                if (i_word[3]) begin
                    s.fin_skip = fin;
                    s.phase    = (sz == SZ_SIZE) ? PH_SKIP_HI_SIZE : PH_SKIP_HI;
                end else if (fin) begin
                    end_walk = 1'b1;
                end else if (sz == SZ_SIZE) begin
                    s.phase = PH_SIZE;
                end else begin
                    end_pass = 1'b1;
                end
            end

            if (end_pass) begin
                s.outer = s.outer + CNT_W'(1);
                s.inner = '0;
                if (s.outer >= CNT_W'(SAFETY_LIMIT)) begin
                    end_walk = 1'b1;
                end else begin
                    s.phase = PH_SCAN;
                end
            end

            if (end_walk) begin
                if (s.cur_part == i_target) begin
                    s.phase = PH_DONE;
                    done    = 1'b1;
                    hit     = 1'b1;
                end else begin
                    s.phase = PH_FIND;
                    do_find = rescan;
                end
            end

            if (do_find) begin
                s.read_addr = s.read_addr + WORD_STEP;
                if (i_word[0]) begin
                    if (tag == TAG_END) begin
                        s.phase = PH_DONE;
                        done    = 1'b1;
                    end else if (tag == TAG_COMP) begin
                        s.cur_part = i_word[19:8];
                        s.phase    = PH_COMP2;
                    end
                end
            end
        end

        o_state                 = s;
        o_result.next_read_addr = s.read_addr;
        o_result.scan_done      = done;
        o_result.core_found     = hit;
        o_result.core_part      = hit ? s.cur_part : 12'd0;
        o_result.core_revision  = hit ? s.cur_rev : 8'd0;
        o_result.reg_base       = hit ? {s.found_reg, 12'd0} : 32'd0;
        o_result.wrapper_base   = hit ? {s.found_wrap, 12'd0} : 32'd0;
    end

endmodule

[hdl/ecds_chk.sv]
// ----------------------------------------------------------------------------
// Descriptor scan port checker
// Port-level properties of the scan unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "erom_core_descriptor_scan_unit_assert.svh"

module ecds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_next_read_addr,
    input logic        o_scan_done,
    input logic        o_core_found,
    input logic [11:0] o_core_part,
    input logic [7:0]  o_core_revision,
    input logic [31:0] o_reg_base,
    input logic [31:0] o_wrapper_base
);

    logic         found_shown;
    logic         miss_shown;
    logic         core_zero;
    logic         base_low_zero;
    logic         in_start;
    logic         result_open;
    logic         out_stall;
    logic [117:0] out_word;

    assign found_shown   = o_out_valid && o_core_found;
    assign miss_shown    = o_out_valid && !o_core_found;
    assign core_zero     = (o_core_part == 12'd0) && (o_core_revision == 8'd0)
                           && (o_reg_base == 32'd0) && (o_wrapper_base == 32'd0);
    assign base_low_zero = (o_reg_base[11:0] == 12'd0) && (o_wrapper_base[11:0] == 12'd0);
    assign in_start      = i_in_valid && o_in_ready && i_func;
    assign result_open   = o_out_valid && !o_scan_done;
    assign out_stall     = o_out_valid && !i_out_ready;
    assign out_word      = {o_next_read_addr, o_scan_done, o_core_found, o_core_part,
                            o_core_revision, o_reg_base, o_wrapper_base};

    // a hit is only reported on the step that ends the scan
    `ECDS_ASSERT_SAME(a_found_needs_done, found_shown, o_scan_done, "hit without scan done")

    // without a hit all core fields read zero
    `ECDS_ASSERT_SAME(a_miss_zero, miss_shown, core_zero, "core fields set without a hit")

    // window bases are 4K aligned
    `ECDS_ASSERT_SAME(a_base_aligned, o_out_valid, base_low_zero, "window base not 4K aligned")

    // a start transaction gives a result that does not end the scan
    `ECDS_ASSERT_NEXT(a_start_not_done, in_start, result_open, "start ended the scan")

    // a stalled result holds
    `ECDS_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(out_word), "stall not held")

endmodule

bind erom_core_descriptor_scan_unit ecds_chk u_ecds_chk (.*);

[tb/ecds_scan_monitor.sv]
// ----------------------------------------------------------------------------
// Descriptor scan monitor
// Follows the configuration writes and both channels of the scan unit, keeps
// its own copy of the scan state, works out the result of every accepted
// input transaction and compares it field by field with the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecds_scan_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_desc_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_next_read_addr,
    input  logic        i_scan_done,
    input  logic        i_core_found,
    input  logic [11:0] i_core_part,
    input  logic [7:0]  i_core_revision,
    input  logic [31:0] i_reg_base,
    input  logic [31:0] i_wrapper_base,
    output int          o_pending,
    output int          o_fail_count
);

    import ecds_pkg::*;

    logic [11:0] cfg_target;
    logic [31:0] cfg_base;

    t_phase      scan_ph;
    logic [31:0] read_addr;
    logic [11:0] cur_part;
    logic [7:0]  cur_rev;
    logic [1:0]  wrap_kind;
    logic [19:0] found_reg;
    logic [19:0] found_wrap;
    int          inner_cnt;
    int          outer_cnt;
    logic        fin_skip;
    logic        done_now;
    logic        hit_now;

    t_result     expected_results[$];
    int          fail_cnt = 0;

    function automatic void clear_scan();
        scan_ph    = PH_IDLE;
        read_addr  = '0;
        cur_part   = '0;
        cur_rev    = '0;
        wrap_kind  = '0;
        found_reg  = '0;
        found_wrap = '0;
        inner_cnt  = 0;
        outer_cnt  = 0;
        fin_skip   = 1'b0;
    endfunction

    // returns 1 when the scan ends on the target
    function automatic bit close_component();
        if (cur_part == cfg_target) begin
            scan_ph  = PH_DONE;
            done_now = 1'b1;
            hit_now  = 1'b1;
            return 1'b1;
        end
        scan_ph = PH_FIND;
        return 1'b0;
    endfunction

    function automatic void close_pass();
        outer_cnt++;
        inner_cnt = 0;
        if (outer_cnt >= SAFETY_LIMIT)
            void'(close_component());
        else
            scan_ph = PH_SCAN;
    endfunction

    function automatic void take_addr_entry(logic [31:0] w);
        logic [1:0] sz;
        logic [1:0] st;
        logic       fin;
        sz  = w[5:4];
        st  = w[7:6];
        fin = 1'b0;
        // only 4K and 8K windows are taken
        if (sz <= 2'd1) begin
            if (found_reg == '0 && st == ST_SLAVE)
                found_reg = w[31:12];
            if (found_wrap == '0 && st == wrap_kind)
                found_wrap = w[31:12];
            fin = (found_reg != '0) && (found_wrap != '0);
        end
        if (w[3]) begin
            fin_skip = fin;
            scan_ph  = (sz == SZ_SIZE) ? PH_SKIP_HI_SIZE : PH_SKIP_HI;
        end else if (fin) begin
            void'(close_component());
        end else if (sz == SZ_SIZE) begin
            scan_ph = PH_SIZE;
        end else begin
            close_pass();
        end
    endfunction

    // returns 1 when the word is handed on to the next phase
    function automatic bit consume_word(logic [31:0] w);
        logic [3:0] tag;
        tag = w[3:0];
        case (scan_ph)
            PH_FIND: begin
                read_addr += WORD_STEP;
                if (w[0]) begin
                    if (tag == TAG_END) begin
                        scan_ph  = PH_DONE;
                        done_now = 1'b1;
                    end else if (tag == TAG_COMP) begin
                        cur_part = w[19:8];
                        scan_ph  = PH_COMP2;
                    end
                end
                return 1'b0;
            end
            PH_COMP2: begin
                read_addr += WORD_STEP;
                cur_rev = w[31:24];
                // no wrappers at all: skip the component
                if (w[23:14] == '0) begin
                    scan_ph = PH_FIND;
                end else begin
                    found_reg  = '0;
                    found_wrap = '0;
                    scan_ph    = PH_FIRST;
                end
                return 1'b0;
            end
            PH_FIRST: begin
                inner_cnt = 0;
                outer_cnt = 0;
                fin_skip  = 1'b0;
                if (tag == TAG_MPORT) begin
                    read_addr += WORD_STEP;
                    wrap_kind = WRAP_MASTER;
                    scan_ph   = PH_SCAN;
                    return 1'b0;
                end
                if (tag[2:0] == TAG_ADDR) begin
                    wrap_kind = WRAP_SLAVE;
                    scan_ph   = PH_SCAN;
                    return 1'b1;
                end
                return !close_component();
            end
            PH_SCAN: begin
                if (tag == TAG_END || tag == TAG_COMP)
                    return !close_component();
                read_addr += WORD_STEP;
                if (tag[2:0] == TAG_ADDR) begin
                    take_addr_entry(w);
                end else begin
                    inner_cnt++;
                    if (inner_cnt >= SAFETY_LIMIT)
                        take_addr_entry(w);
                end
                return 1'b0;
            end
            PH_SKIP_HI: begin
                read_addr += WORD_STEP;
                if (fin_skip)
                    void'(close_component());
                else
                    close_pass();
                return 1'b0;
            end
            PH_SKIP_HI_SIZE: begin
                read_addr += WORD_STEP;
                scan_ph = PH_SIZE;
                return 1'b0;
            end
            PH_SIZE: begin
                read_addr += WORD_STEP;
                if (w[3])
                    scan_ph = PH_SKIP_SIZE_HI;
                else
                    close_pass();
                return 1'b0;
            end
            PH_SKIP_SIZE_HI: begin
                read_addr += WORD_STEP;
                close_pass();
                return 1'b0;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_result predict_step(logic func, logic [31:0] w);
        t_result r;
        int      g;
        done_now = 1'b0;
        hit_now  = 1'b0;
        if (func) begin
            clear_scan();
            scan_ph   = PH_FIND;
            read_addr = cfg_base;
        end else begin
            for (g = 0; g < 4; g++) begin
                if (!consume_word(w))
                    break;
            end
        end
        r.next_read_addr = read_addr;
        r.scan_done      = done_now;
        r.core_found     = hit_now;
        r.core_part      = hit_now ? cur_part : '0;
        r.core_revision  = hit_now ? cur_rev : '0;
        r.reg_base       = hit_now ? {found_reg, 12'h000} : '0;
        r.wrapper_base   = hit_now ? {found_wrap, 12'h000} : '0;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : p_track
        t_result exp_r;
        if (!i_rst_n) begin
            clear_scan();
            cfg_target = '0;
            cfg_base   = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TARGET)
                    cfg_target = i_cfg_data[11:0];
                else
                    cfg_base = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_step(i_func, i_desc_word));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with none expected, actual addr %h done %b",
                             $time, i_next_read_addr, i_scan_done);
                    fail_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("next_read_addr", exp_r.next_read_addr, i_next_read_addr);
                    compare_field("scan_done", exp_r.scan_done, i_scan_done);
                    compare_field("core_found", exp_r.core_found, i_core_found);
                    compare_field("core_part", exp_r.core_part, i_core_part);
                    compare_field("core_revision", exp_r.core_revision, i_core_revision);
                    compare_field("reg_base", exp_r.reg_base, i_reg_base);
                    compare_field("wrapper_base", exp_r.wrapper_base, i_wrapper_base);
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

[tb/erom_core_descriptor_scan_unit_tb.sv]
// ----------------------------------------------------------------------------
// Descriptor scan unit testbench
// Feeds start and descriptor word transactions built as small ROM tables
// (components, address entries, trailing words, safety-limit runs and noise)
// under several register settings, with random gaps on both channels; the
// scan monitor predicts and checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erom_core_descriptor_scan_unit_tb;

    import ecds_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_TARGET;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_func      = 1'b0;
    logic [31:0] i_desc_word = '0;
    logic        i_out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_next_read_addr;
    logic        o_scan_done;
    logic        o_core_found;
    logic [11:0] o_core_part;
    logic [7:0]  o_core_revision;
    logic [31:0] o_reg_base;
    logic [31:0] o_wrapper_base;

    int          pending_results;
    int          fail_count;

    logic [31:0] rom_words[$];
    logic [11:0] cur_target  = '0;
    int          items_sent  = 0;
    bit          burst       = 1'b0;
    int          ready_hold  = 0;
    int          idle_cycles = 0;

    erom_core_descriptor_scan_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_desc_word      (i_desc_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_next_read_addr (o_next_read_addr),
        .o_scan_done      (o_scan_done),
        .o_core_found     (o_core_found),
        .o_core_part      (o_core_part),
        .o_core_revision  (o_core_revision),
        .o_reg_base       (o_reg_base),
        .o_wrapper_base   (o_wrapper_base)
    );

    ecds_scan_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_desc_word      (i_desc_word),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_next_read_addr (o_next_read_addr),
        .i_scan_done      (o_scan_done),
        .i_core_found     (o_core_found),
        .i_core_part      (o_core_part),
        .i_core_revision  (o_core_revision),
        .i_reg_base       (o_reg_base),
        .i_wrapper_base   (o_wrapper_base),
        .o_pending        (pending_results),
        .o_fail_count     (fail_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure: mostly ready, short and occasional long stalls
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold  <= 0;
        end else if (ready_hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(0, 15);
            end else if (r < 88) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 2);
            end else if (r < 96) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(40, 120);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(10, 40);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a clock edge; returns at the edge where the transaction is taken
    task automatic send_item(logic func, logic [31:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_desc_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] word_with_tag(logic [3:0] tag);
        logic [31:0] w;
        w = $urandom;
        w[3:0] = tag;
        return w;
    endfunction

    // scan phase filler: counts towards the inner pass limit
    function automatic logic [3:0] filler_tag();
        logic [3:0] t;
        do t = 4'($urandom_range(0, 15));
        while (t == TAG_COMP || t == TAG_END || t[2:0] == TAG_ADDR);
        return t;
    endfunction

    function automatic void push_addr_entry(logic [1:0] sz, logic [1:0] st, logic hi);
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) == 0)
            w[31:12] = '0;
        w[7:6] = st;
        w[5:4] = sz;
        w[3]   = hi;
        w[2:0] = TAG_ADDR;
        rom_words.push_back(w);
        if (hi)
            rom_words.push_back($urandom);
        if (sz == SZ_SIZE) begin
            w = $urandom;
            w[3] = ($urandom_range(0, 2) == 0);
            rom_words.push_back(w);
            if (w[3])
                rom_words.push_back($urandom);
        end
    endfunction

    function automatic void push_random_addr();
        int         r;
        logic [1:0] sz;
        logic [1:0] st;
        r  = $urandom_range(0, 99);
        sz = (r < 40) ? 2'd0 : (r < 70) ? 2'd1 : (r < 85) ? 2'd2 : SZ_SIZE;
        r  = $urandom_range(0, 99);
        st = (r < 40) ? ST_SLAVE : (r < 55) ? 2'd1 : (r < 75) ? WRAP_SLAVE : WRAP_MASTER;
        push_addr_entry(sz, st, $urandom_range(0, 3) == 0);
    endfunction

    // body 0: normal walk, 1: long filler run, 2: long run of untaken passes
    function automatic void push_component(int body);
        logic [31:0] w;
        logic [3:0]  t;
        int          n;
        int          r;
        // noise the search phase steps over
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            w = $urandom;
            if (w[3:0] == TAG_COMP || w[3:0] == TAG_END)
                w[0] = 1'b0;
            rom_words.push_back(w);
        end
        w = word_with_tag(TAG_COMP);
        w[19:8] = ($urandom_range(0, 99) < 35) ? cur_target : 12'($urandom);
        rom_words.push_back(w);
        w = $urandom;
        if (body == 0 && $urandom_range(0, 9) == 0)
            w[23:14] = '0;
        else if (w[23:14] == '0)
            w[14] = 1'b1;
        rom_words.push_back(w);
        if (body == 2) begin
            push_addr_entry(2'd2, ST_SLAVE, 1'b0);
            repeat (SAFETY_LIMIT + 2) push_addr_entry(2'd2, 2'($urandom), 1'b0);
            return;
        end
        r = $urandom_range(0, 99);
        if (body == 1 || r < 45) begin
            rom_words.push_back(word_with_tag(TAG_MPORT));
        end else if (r < 90) begin
            push_random_addr();
        end else begin
            do t = 4'($urandom_range(0, 15));
            while (t == TAG_MPORT || t[2:0] == TAG_ADDR);
            rom_words.push_back(word_with_tag(t));
        end
        if (body == 1)
            repeat (SAFETY_LIMIT + 4) rom_words.push_back(word_with_tag(filler_tag()));
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                rom_words.push_back(word_with_tag(filler_tag()));
            push_random_addr();
        end
    endfunction

    task automatic run_scan(int body);
        int r;
        int k;
        rom_words.delete();
        burst = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (body == 0 && r < 12) begin
            repeat ($urandom_range(4, 30)) rom_words.push_back($urandom);
        end else begin
            push_component(body);
            repeat ($urandom_range(0, 3)) push_component(0);
            if (r < 85) begin
                rom_words.push_back(word_with_tag(TAG_END));
            end else if (r < 93) begin
                // cut short: the next start drops this scan
                k = $urandom_range(1, rom_words.size());
                while (rom_words.size() > k) void'(rom_words.pop_back());
            end
            // words after the end are ignored
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) rom_words.push_back($urandom);
        end
        send_item(1'b1, $urandom);
        foreach (rom_words[i])
            send_item(1'b0, rom_words[i]);
    endtask

    task automatic run_phase(logic [11:0] tgt, logic [31:0] base, int budget, int body);
        logic [31:0] data;
        int          first_item;
        drain();
        data = $urandom;
        data[11:0] = tgt;
        cfg_write(CFG_TARGET, data);
        cfg_write(CFG_BASE, base);
        cur_target = tgt;
        first_item = items_sent;
        if (body != 0)
            run_scan(body);
        while (items_sent - first_item < budget)
            run_scan(0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // words before any start are ignored
        send_item(1'b0, 32'hffff_ffff);
        send_item(1'b0, 32'h0000_0000);

        // directed walk near the top of the address space
        run_phase(12'hfff, 32'hffff_fff0, 0, 0);
        burst = 1'b0;
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);   // even word, stepped over
        send_item(1'b0, 32'h0012_3451);   // component
        send_item(1'b0, 32'h0000_3fff);   // no wrappers, component skipped
        send_item(1'b0, 32'hffff_fff1);   // target component
        send_item(1'b0, 32'hffff_ffff);
        send_item(1'b0, 32'h0000_0003);   // master port first word
        send_item(1'b0, 32'hffff_f005);   // slave 4K window
        send_item(1'b0, 32'h0000_10cd);   // master wrapper with high word
        send_item(1'b0, 32'hffff_ffff);   // high word, target found
        send_item(1'b0, 32'h1234_5678);   // ignored after the end
        send_item(1'b1, 32'hffff_ffff);
        send_item(1'b0, 32'h0000_0011);   // component, not the target
        send_item(1'b0, 32'h0000_4000);
        send_item(1'b0, 32'h0000_0001);   // bad first word, rescanned as component
        send_item(1'b0, 32'h0100_4000);
        send_item(1'b0, 32'h0000_2015);   // address first word, handed on to the walk
        send_item(1'b0, 32'h0000_30b5);   // size entry
        send_item(1'b0, 32'h0000_0008);   // size word with high part
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h0000_4fe5);   // 16K window, not taken
        send_item(1'b0, 32'h0000_0000);   // filler
        send_item(1'b0, 32'h0000_000f);   // end of table
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b0, 32'hffff_fff1);
        send_item(1'b1, 32'h0000_0000);   // restart in the middle of a scan
        send_item(1'b0, 32'hffff_ffff);

        run_phase(12'hfff, 32'hffff_fff0, 200, 0);
        run_phase(12'h000, 32'h0000_0000, 220, 0);
        run_phase(12'($urandom), $urandom, 220, 1);
        run_phase(12'($urandom), 32'hffff_fffc, 220, 0);
        run_phase(12'($urandom), $urandom, 220, 2);
        run_phase(12'h000, 32'hffff_ffff, 220, 0);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
